// File: hdl/ifbs_pkg.sv
// Shared constants and types of the information frame byte stuffer.
package ifbs_pkg;

  // Byte width on both sides of the block.
  localparam int unsigned BYTE_W = 8;

  // Longest run of line bytes caused by one payload byte:
  // four header bytes, stuffed data, stuffed check byte and closing flag.
  localparam int unsigned RUN_MAX = 9;
  localparam int unsigned RUN_W   = $clog2(RUN_MAX + 1);

  // Framing codes.
  localparam logic [BYTE_W-1:0] FRAME_FLAG   = 8'h5c;
  localparam logic [BYTE_W-1:0] ESCAPE_BYTE  = 8'h5d;
  localparam logic [BYTE_W-1:0] FLAG_SUBST   = 8'h7c;
  localparam logic [BYTE_W-1:0] ESCAPE_SUBST = 8'h7d;
  localparam logic [BYTE_W-1:0] CTRL_SEQ0    = 8'h80;
  localparam logic [BYTE_W-1:0] CTRL_SEQ1    = 8'hc0;
  localparam logic [BYTE_W-1:0] ADDR_RESET   = 8'h01;

  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [RUN_W-1:0]  run_cnt_t;

endpackage

// File: hdl/ifbs_in_if.sv
// Request channel carrying payload bytes into the stuffer.
interface ifbs_in_if;
  logic                  valid;
  logic                  ready;
  logic [ifbs_pkg::BYTE_W-1:0] data_byte;
  logic                  seq_bit;
  logic                  last_byte;

  modport source (output valid, output data_byte, output seq_bit, output last_byte,
                  input ready);
  modport sink   (input valid, input data_byte, input seq_bit, input last_byte,
                  output ready);
endinterface

// File: hdl/ifbs_out_if.sv
// Request channel carrying line bytes out of the stuffer.
interface ifbs_out_if;
  logic                  valid;
  logic                  ready;
  logic [ifbs_pkg::BYTE_W-1:0] line_byte;
  logic                  run_end;

  modport source (output valid, output line_byte, output run_end, input ready);
  modport sink   (input valid, input line_byte, input run_end, output ready);
endinterface

// File: hdl/ifbs_cfg_if.sv
// Write channel for the station address register.
interface ifbs_cfg_if;
  logic                  valid;
  logic                  ready;
  logic [ifbs_pkg::BYTE_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: hdl/info_frame_byte_stuffer.sv
// Information frame byte stuffer. Each accepted payload byte produces a run of 1 to 9 line
// bytes, one per cycle while out_o.ready is high, the final one marked with run_end: a
// four-byte header (flag, station address, control, address XOR control) on a frame's first
// byte, the payload byte stuffed (0x5c as 0x5d 0x7c, 0x5d as 0x5d 0x7d), and after the last
// byte the stuffed XOR check byte and a closing flag. An accepted byte is held in the input
// register and then its whole run is loaded into the output shift register, from which the
// line bytes are offered. The output side moves one line byte per cycle while out_o.ready is
// high, and that sets the rate: a payload byte has one or two line bytes mid-frame, and the
// input register takes the next byte while the current run drains. The station address is
// written through the configuration channel, resets to 0x01 and is used at the next header.
module info_frame_byte_stuffer (
  input  logic       clk_i,
  input  logic       rst_ni,
  ifbs_cfg_if.sink   cfg_i,
  ifbs_in_if.sink    in_i,
  ifbs_out_if.source out_o
);
  import ifbs_pkg::*;

  // Station address register.
  byte_t addr_q;

  // Input register.
  logic  in_vld_q;
  byte_t in_data_q;
  logic  in_seq_q;
  logic  in_last_q;

  // Frame state.
  logic  inside_q, inside_d;
  byte_t check_q, check_d;

  // Output shift register and remaining byte count.
  byte_t    run_q [RUN_MAX];
  byte_t    run_d [RUN_MAX];
  run_cnt_t cnt_q, cnt_d;

  // Run built from the registered input byte.
  byte_t    list [RUN_MAX];
  run_cnt_t list_len;

  logic take;
  logic load;
  logic in_take;

  assign cfg_i.ready = 1'b1;

  // Handshake control: load a new run from the input register when the output register is empty or empties this cycle.
  assign take    = out_o.valid & out_o.ready;
  assign load    = in_vld_q & ((cnt_q == '0) | ((cnt_q == run_cnt_t'(1)) & take));
  assign in_i.ready = ~in_vld_q | load;
  assign in_take = in_i.valid & in_i.ready;

  // Build the line bytes for the byte in the input register.
  always_comb begin
    byte_t ctrl;
    byte_t chk;
    run_cnt_t n;
    for (int i = 0; i < RUN_MAX; i++) begin
      list[i] = '0;
    end
    n    = '0;
    ctrl = in_seq_q ? CTRL_SEQ1 : CTRL_SEQ0;
    chk  = (inside_q ? check_q : '0) ^ in_data_q;
    if (!inside_q) begin
      list[0] = FRAME_FLAG;
      list[1] = addr_q;
      list[2] = ctrl;
      list[3] = addr_q ^ ctrl;
      n = run_cnt_t'(4);
    end
    // Payload byte, stuffed.
    if (in_data_q == FRAME_FLAG || in_data_q == ESCAPE_BYTE) begin
      list[n]                 = ESCAPE_BYTE;
      list[n + run_cnt_t'(1)] = (in_data_q == FRAME_FLAG) ? FLAG_SUBST : ESCAPE_SUBST;
      n = n + run_cnt_t'(2);
    end else begin
      list[n] = in_data_q;
      n = n + run_cnt_t'(1);
    end
    // Trailer: stuffed check byte and closing flag.
    if (in_last_q) begin
      if (chk == FRAME_FLAG || chk == ESCAPE_BYTE) begin
        list[n]                 = ESCAPE_BYTE;
        list[n + run_cnt_t'(1)] = (chk == FRAME_FLAG) ? FLAG_SUBST : ESCAPE_SUBST;
        n = n + run_cnt_t'(2);
      end else begin
        list[n] = chk;
        n = n + run_cnt_t'(1);
      end
      list[n] = FRAME_FLAG;
      n = n + run_cnt_t'(1);
    end
    list_len = n;
    inside_d = inside_q;
    check_d  = check_q;
    if (load) begin
      inside_d = ~in_last_q;
      check_d  = in_last_q ? '0 : chk;
    end
  end

  // Next value of the output shift register.
  always_comb begin
    for (int i = 0; i < RUN_MAX; i++) begin
      run_d[i] = run_q[i];
    end
    cnt_d = cnt_q;
    if (load) begin
      for (int i = 0; i < RUN_MAX; i++) begin
        run_d[i] = list[i];
      end
      cnt_d = list_len;
    end else if (take) begin
      for (int i = 0; i < RUN_MAX - 1; i++) begin
        run_d[i] = run_q[i + 1];
      end
      cnt_d = cnt_q - run_cnt_t'(1);
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q   <= ADDR_RESET;
      in_vld_q <= 1'b0;
      inside_q <= 1'b0;
      check_q  <= '0;
      cnt_q    <= '0;
    end else begin
      if (cfg_i.valid) begin
        addr_q <= cfg_i.data;
      end
      if (in_take) begin
        in_vld_q <= 1'b1;
      end else if (load) begin
        in_vld_q <= 1'b0;
      end
      inside_q <= inside_d;
      check_q  <= check_d;
      cnt_q    <= cnt_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_data_q <= in_i.data_byte;
      in_seq_q  <= in_i.seq_bit;
      in_last_q <= in_i.last_byte;
    end
    for (int i = 0; i < RUN_MAX; i++) begin
      run_q[i] <= run_d[i];
    end
  end

  assign out_o.valid     = (cnt_q != '0);
  assign out_o.line_byte = run_q[0];
  assign out_o.run_end   = (cnt_q == run_cnt_t'(1));

endmodule

// File: hdl/ifbs_checker.sv
// Port-level checks of the information frame byte stuffer, with their bind statement.
module ifbs_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_i,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic [ifbs_pkg::BYTE_W-1:0] out_line_byte_i,
  input logic                        out_run_end_i
);
  import ifbs_pkg::*;

  // A pending output request holds until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("output request dropped before it was taken");

  // A stalled output request keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_line_byte_i) && $stable(out_run_end_i))
    else $error("stalled output payload changed");

  // A run of line bytes never breaks before its end mark.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && !out_run_end_i |=> out_valid_i)
    else $error("line byte run interrupted before its end");

  // The input side stalls only while line bytes are pending.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_i |-> out_valid_i)
    else $error("input stalled with no output pending");

endmodule

bind info_frame_byte_stuffer ifbs_checker u_ifbs_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_i.valid),
  .in_ready_i      (in_i.ready),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .out_line_byte_i (out_o.line_byte),
  .out_run_end_i   (out_o.run_end)
);
